// File: src/assert_macros.svh
// assertion helpers for the rtl files, used by the converter core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every clock, quiet while reset is high
`define ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_HOLDS(label, prop, msg)

`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: src/rsc_pkg.sv
`default_nettype none

package rsc_pkg;

  localparam int MAX_BASE    = 16;
  localparam int ALPHA_SIZE  = 16;
  localparam int DIGIT_W     = 4;
  localparam int BUF_DEPTH   = 32;
  localparam int BUF_AW      = $clog2(BUF_DEPTH);
  localparam int COUNT_W     = $clog2(BUF_DEPTH) + 1;
  localparam int VALUE_W     = 32;
  localparam int LEN_W       = 5;
  localparam int CHAR_W      = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int DIV_BITS    = 8;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SOURCE_LENGTH      = 3'd0,
    CFG_TARGET_LENGTH      = 3'd1,
    CFG_SOURCE_DIGITS_LOW  = 3'd2,
    CFG_SOURCE_DIGITS_HIGH = 3'd3,
    CFG_TARGET_DIGITS_LOW  = 3'd4,
    CFG_TARGET_DIGITS_HIGH = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } parse_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              out_last;
    logic              out_error;
  } out_item_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_status_t;

  function automatic logic [CHAR_W-1:0] alpha_char(logic [CFG_DATA_W-1:0] lo,
                                                   logic [CFG_DATA_W-1:0] hi,
                                                   logic [DIGIT_W-1:0] idx);
    logic [CFG_DATA_W-1:0] word;
    word = idx[3] ? hi : lo;
    return word[{idx[2:0], 3'b000} +: CHAR_W];
  endfunction

  function automatic logic is_space(logic [CHAR_W-1:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  // length in range, no sign, blank or nul characters, no repeats
  function automatic logic alphabet_ok(logic [LEN_W-1:0] len, logic [CFG_DATA_W-1:0] lo,
                                       logic [CFG_DATA_W-1:0] hi);
    logic              ok;
    logic [CHAR_W-1:0] ca;
    ok = (len >= LEN_W'(2)) && (len <= LEN_W'(MAX_BASE));
    for (int a = 0; a < ALPHA_SIZE; a++) begin
      if (LEN_W'(a) < len) begin
        ca = alpha_char(lo, hi, DIGIT_W'(a));
        if ((ca == CHAR_NUL) || (ca == CHAR_PLUS) || (ca == CHAR_MINUS) || is_space(ca)) begin
          ok = 1'b0;
        end
        for (int b = a + 1; b < ALPHA_SIZE; b++) begin
          if ((LEN_W'(b) < len) && (alpha_char(lo, hi, DIGIT_W'(b)) == ca)) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

// File: src/rsc_ram.sv
`default_nettype none

module rsc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/rsc_divider.sv
`default_nettype none

// restoring divider by a small divisor, DIV_BITS quotient bits per cycle
module rsc_divider import rsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  input  logic [LEN_W-1:0]   divisor,
  output div_status_t        status
);

  localparam int STEPS   = VALUE_W / DIV_BITS;
  localparam int STEP_CW = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic               busy;
  logic               done;
  logic [STEP_CW-1:0] step;
  logic [VALUE_W-1:0] quo;
  logic [DIGIT_W-1:0] rem;

  logic [VALUE_W-1:0] quo_next;
  logic [DIGIT_W-1:0] rem_next;
  logic [LEN_W-1:0]   trial;

  always_comb begin
    quo_next = quo;
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial    = {rem_next, quo_next[VALUE_W-1]};
      quo_next = {quo_next[VALUE_W-2:0], 1'b0};
      if (trial >= divisor) begin
        trial       = trial - divisor;
        quo_next[0] = 1'b1;
      end
      rem_next = trial[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_CW'(1);
      if (step == STEP_CW'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign status.done      = done;
  assign status.quotient  = quo;
  assign status.remainder = rem;

endmodule

`default_nettype wire

// File: src/radix_string_converter_core.sv
// a character that is not last is taken in the idle state, the next one can follow at once
// last character: accept and alphabet check, then for each target digit a run of the shared
//   divider (8 quotient bits at a time) and a store of the digit, then a minus sign if needed
//   and a buffer read for each emitted digit; a result has at most 32 digits
// error and zero results leave from the check state; no new item until the last result is loaded
// rst is synchronous, active high: parse state, sequencer, counters and configuration to their reset values
`default_nettype none

`include "assert_macros.svh"

module radix_string_converter_core import rsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [LEN_W-1:0]      source_length;
  logic [LEN_W-1:0]      target_length;
  logic [CFG_DATA_W-1:0] source_digits_low;
  logic [CFG_DATA_W-1:0] source_digits_high;
  logic [CFG_DATA_W-1:0] target_digits_low;
  logic [CFG_DATA_W-1:0] target_digits_high;

  // parse state
  parse_phase_t       parse_phase;
  parse_phase_t       parse_phase_next;
  logic               negative;
  logic               negative_next;
  logic [VALUE_W-1:0] accumulator;
  logic [VALUE_W-1:0] accumulator_next;

  // sequencer
  ctl_state_t         state;
  ctl_state_t         state_next;
  logic [COUNT_W-1:0] digit_count;
  logic [COUNT_W-1:0] digit_count_next;
  logic               sign_pending;
  logic               sign_pending_next;
  out_item_t          out_next;
  logic               out_load;

  // parse datapath
  parse_phase_t       step_phase;
  logic               step_negative;
  logic [VALUE_W-1:0] step_accumulator;
  logic               found;
  logic [DIGIT_W-1:0] match_idx;

  // conversion datapath
  logic               alpha_valid;
  logic [VALUE_W-1:0] signed_value;
  logic [VALUE_W-1:0] magnitude;
  logic               value_negative;
  logic               out_free;
  logic               in_accept;

  // shared divider and digit buffer
  logic               div_start;
  logic [VALUE_W-1:0] div_dividend;
  div_status_t        div_status;
  logic               buf_we;
  logic [COUNT_W-1:0] buf_rindex;
  logic [BUF_AW-1:0]  buf_raddr;
  logic [DIGIT_W-1:0] buf_rdata;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      source_length      <= LEN_W'(2);
      target_length      <= LEN_W'(2);
      source_digits_low  <= '0;
      source_digits_high <= '0;
      target_digits_low  <= '0;
      target_digits_high <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SOURCE_LENGTH:      source_length      <= cfg_data[LEN_W-1:0];
        CFG_TARGET_LENGTH:      target_length      <= cfg_data[LEN_W-1:0];
        CFG_SOURCE_DIGITS_LOW:  source_digits_low  <= cfg_data;
        CFG_SOURCE_DIGITS_HIGH: source_digits_high <= cfg_data;
        CFG_TARGET_DIGITS_LOW:  target_digits_low  <= cfg_data;
        CFG_TARGET_DIGITS_HIGH: target_digits_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // source digit lookup, lowest matching index wins
  always_comb begin
    found     = 1'b0;
    match_idx = '0;
    for (int j = ALPHA_SIZE - 1; j >= 0; j--) begin
      if ((LEN_W'(j) < source_length) &&
          (alpha_char(source_digits_low, source_digits_high, DIGIT_W'(j)) == in_data.in_char)) begin
        found     = 1'b1;
        match_idx = DIGIT_W'(j);
      end
    end
  end

  // one character of parsing: blanks, then signs, then digits until the first stranger
  always_comb begin
    step_phase       = parse_phase;
    step_negative    = negative;
    step_accumulator = accumulator;
    if ((parse_phase == PH_SPACE) && is_space(in_data.in_char)) begin
      step_phase = PH_SPACE;
    end else if (((parse_phase == PH_SPACE) || (parse_phase == PH_SIGN)) &&
                 ((in_data.in_char == CHAR_PLUS) || (in_data.in_char == CHAR_MINUS))) begin
      step_phase = PH_SIGN;
      if (in_data.in_char == CHAR_MINUS) begin
        step_negative = !negative;
      end
    end else if (parse_phase != PH_DONE) begin
      if (found) begin
        step_accumulator = VALUE_W'(accumulator * VALUE_W'(source_length)) +
                           VALUE_W'(match_idx);
        step_phase       = PH_DIGITS;
      end else begin
        step_phase = PH_DONE;
      end
    end
  end

  // final value: apply the sign, wrap to 32 bits, then take the magnitude
  assign alpha_valid = alphabet_ok(source_length, source_digits_low, source_digits_high) &&
                       alphabet_ok(target_length, target_digits_low, target_digits_high);
  assign signed_value   = negative ? (VALUE_W'(0) - accumulator) : accumulator;
  assign value_negative = signed_value[VALUE_W-1];
  assign magnitude      = value_negative ? (VALUE_W'(0) - signed_value) : signed_value;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && in_data.in_last) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!alpha_valid || (magnitude == '0)) begin
          if (out_free) begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_status.done &&
            ((div_status.quotient == '0) || (digit_count == COUNT_W'(BUF_DEPTH - 1)))) begin
          state_next = sign_pending ? ST_SIGN : ST_READ;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = (digit_count == COUNT_W'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs and register updates
  always_comb begin
    in_stall          = 1'b1;
    parse_phase_next  = parse_phase;
    negative_next     = negative;
    accumulator_next  = accumulator;
    digit_count_next  = digit_count;
    sign_pending_next = sign_pending;
    div_start         = 1'b0;
    div_dividend      = div_status.quotient;
    buf_we            = 1'b0;
    out_load          = 1'b0;
    out_next          = '{out_char: CHAR_NUL, out_last: 1'b0, out_error: 1'b0};
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_accept) begin
          parse_phase_next = step_phase;
          negative_next    = step_negative;
          accumulator_next = step_accumulator;
        end
      end
      ST_CHECK: begin
        if (!alpha_valid || (magnitude == '0)) begin
          // single result: error marker, or the literal zero
          if (out_free) begin
            out_load = 1'b1;
            if (!alpha_valid) begin
              out_next = '{out_char: CHAR_NUL, out_last: 1'b1, out_error: 1'b1};
            end else begin
              out_next = '{out_char: CHAR_ZERO, out_last: 1'b1, out_error: 1'b0};
            end
            parse_phase_next = PH_SPACE;
            negative_next    = 1'b0;
            accumulator_next = '0;
          end
        end else begin
          div_start         = 1'b1;
          div_dividend      = magnitude;
          digit_count_next  = '0;
          sign_pending_next = value_negative;
          parse_phase_next  = PH_SPACE;
          negative_next     = 1'b0;
          accumulator_next  = '0;
        end
      end
      ST_DIVIDE: begin
        // store the digit, least significant first, and keep dividing the quotient
        if (div_status.done) begin
          buf_we           = 1'b1;
          digit_count_next = digit_count + COUNT_W'(1);
          if ((div_status.quotient != '0) && (digit_count != COUNT_W'(BUF_DEPTH - 1))) begin
            div_start = 1'b1;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_next          = '{out_char: CHAR_MINUS, out_last: 1'b0, out_error: 1'b0};
          sign_pending_next = 1'b0;
        end
      end
      ST_READ: ;
      ST_EMIT: begin
        // buffer data for the top remaining digit is ready
        if (out_free) begin
          out_load         = 1'b1;
          out_next         = '{out_char: alpha_char(target_digits_low, target_digits_high,
                                                    buf_rdata),
                               out_last: (digit_count == COUNT_W'(1)),
                               out_error: 1'b0};
          digit_count_next = digit_count - COUNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      parse_phase  <= PH_SPACE;
      negative     <= 1'b0;
      accumulator  <= '0;
      digit_count  <= '0;
      sign_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      parse_phase  <= parse_phase_next;
      negative     <= negative_next;
      accumulator  <= accumulator_next;
      digit_count  <= digit_count_next;
      sign_pending <= sign_pending_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register, payload held while stalled
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  rsc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (target_length),
    .status   (div_status)
  );

  // read address of the top remaining digit
  assign buf_rindex = digit_count - COUNT_W'(1);
  assign buf_raddr  = buf_rindex[BUF_AW-1:0];

  rsc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (BUF_DEPTH)
  ) u_digit_buffer (
    .clk   (clk),
    .we    (buf_we),
    .waddr (digit_count[BUF_AW-1:0]),
    .wdata (div_status.remainder),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  `ASSERT_NEXT(a_last_starts_check, in_valid && !in_stall && in_data.in_last, state == ST_CHECK, "last item did not start conversion")
  `ASSERT_HOLDS(a_div_done_in_divide, !div_status.done || (state == ST_DIVIDE), "divider finished outside the divide state")
  `ASSERT_HOLDS(a_count_in_range, digit_count <= COUNT_W'(BUF_DEPTH), "digit count past buffer depth")
  `ASSERT_HOLDS(a_error_char_zero, !(out_valid && out_data.out_error) || (out_data.out_char == CHAR_NUL), "error result with nonzero char")

endmodule

`default_nettype wire

// File: sim/testbench.sv
`default_nettype none

module testbench;
  import rsc_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_ITEMS  = 280;
  localparam int IDLE_PCT      = 23;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES   = 250;
  localparam int REPORT_LINES  = 40;

  // index past the register map, the block must ignore writes to it
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = CFG_INDEX_W'(CFG_TARGET_DIGITS_HIGH) + 1'b1;

  typedef enum int {
    FAULT_NONE,
    FAULT_SHORT,
    FAULT_LONG,
    FAULT_BAD_CHAR,
    FAULT_REPEAT
  } fault_t;

  // tracks parse state and register mirror, queues the characters each string turns into
  class conversion_scoreboard;
    out_item_t           expected_chars[$];
    int                  errors;
    int                  checked;
    logic [LEN_W-1:0]    src_len;
    logic [LEN_W-1:0]    tgt_len;
    logic [CFG_DATA_W-1:0] src_lo;
    logic [CFG_DATA_W-1:0] src_hi;
    logic [CFG_DATA_W-1:0] tgt_lo;
    logic [CFG_DATA_W-1:0] tgt_hi;
    parse_phase_t        phase;
    logic                sign_flip;
    logic [VALUE_W-1:0]  acc;

    function new();
      src_len   = LEN_W'(2);
      tgt_len   = LEN_W'(2);
      src_lo    = '0;
      src_hi    = '0;
      tgt_lo    = '0;
      tgt_hi    = '0;
      phase     = PH_SPACE;
      sign_flip = 1'b0;
      acc       = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    static function logic [CHAR_W-1:0] symbol_at(logic [CFG_DATA_W-1:0] lo,
                                                 logic [CFG_DATA_W-1:0] hi, int idx);
      logic [2*CFG_DATA_W-1:0] both;
      both = {hi, lo};
      return both[8*idx +: 8];
    endfunction

    static function logic blank(logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    static function logic alphabet_valid(logic [LEN_W-1:0] len, logic [CFG_DATA_W-1:0] lo,
                                         logic [CFG_DATA_W-1:0] hi);
      logic [CHAR_W-1:0] c;
      if (len < 2 || len > MAX_BASE) return 1'b0;
      for (int a = 0; a < len; a++) begin
        c = symbol_at(lo, hi, a);
        if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS || blank(c)) return 1'b0;
        for (int b = a + 1; b < len; b++) begin
          if (symbol_at(lo, hi, b) == c) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SOURCE_LENGTH:      src_len = val[LEN_W-1:0];
        CFG_TARGET_LENGTH:      tgt_len = val[LEN_W-1:0];
        CFG_SOURCE_DIGITS_LOW:  src_lo  = val;
        CFG_SOURCE_DIGITS_HIGH: src_hi  = val;
        CFG_TARGET_DIGITS_LOW:  tgt_lo  = val;
        CFG_TARGET_DIGITS_HIGH: tgt_hi  = val;
        default: ;
      endcase
    endfunction

    function void add_expected(logic [CHAR_W-1:0] c, logic last, logic err);
      out_item_t r;
      r.out_char  = c;
      r.out_last  = last;
      r.out_error = err;
      expected_chars.push_back(r);
    endfunction

    // signed value of the parsed string written out in the target alphabet
    function void convert_number();
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] mag;
      logic [DIGIT_W-1:0] digits[$];
      if (!alphabet_valid(src_len, src_lo, src_hi) || !alphabet_valid(tgt_len, tgt_lo, tgt_hi)) begin
        add_expected(CHAR_NUL, 1'b1, 1'b1);
        return;
      end
      value = sign_flip ? -acc : acc;
      mag   = value[VALUE_W-1] ? -value : value;
      if (mag == '0) begin
        // literal zero character, never a minus
        add_expected(CHAR_ZERO, 1'b1, 1'b0);
        return;
      end
      while (mag != '0) begin
        digits.push_front(DIGIT_W'(mag % VALUE_W'(tgt_len)));
        mag = mag / VALUE_W'(tgt_len);
      end
      if (value[VALUE_W-1]) add_expected(CHAR_MINUS, 1'b0, 1'b0);
      foreach (digits[k]) begin
        add_expected(symbol_at(tgt_lo, tgt_hi, digits[k]), k == digits.size() - 1, 1'b0);
      end
    endfunction

    function void note_char(in_item_t it);
      logic [CHAR_W-1:0] c;
      int hit;
      c = it.in_char;
      if (phase == PH_SPACE && blank(c)) begin
      end else if (phase <= PH_SIGN && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
        phase = PH_SIGN;
        if (c == CHAR_MINUS) sign_flip = ~sign_flip;
      end else if (phase <= PH_DIGITS) begin
        // lowest matching index wins
        hit = -1;
        for (int j = ALPHA_SIZE - 1; j >= 0; j--) begin
          if (j < src_len && symbol_at(src_lo, src_hi, j) == c) hit = j;
        end
        if (hit >= 0) begin
          acc   = acc * VALUE_W'(src_len) + VALUE_W'(hit);
          phase = PH_DIGITS;
        end else begin
          phase = PH_DONE;
        end
      end
      if (!it.in_last) return;
      convert_number();
      phase     = PH_SPACE;
      sign_flip = 1'b0;
      acc       = '0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= REPORT_LINES) $display("mismatch: %s", msg);
    endtask

    task check_char(out_item_t got);
      out_item_t want;
      checked++;
      if (expected_chars.size() == 0) begin
        report($sformatf("result %0d: char %h arrived with nothing expected",
                         checked, got.out_char));
        return;
      end
      want = expected_chars.pop_front();
      if (got.out_char !== want.out_char)
        report($sformatf("result %0d: out_char %h, expected %h",
                         checked, got.out_char, want.out_char));
      if (got.out_last !== want.out_last)
        report($sformatf("result %0d: out_last %b, expected %b",
                         checked, got.out_last, want.out_last));
      if (got.out_error !== want.out_error)
        report($sformatf("result %0d: out_error %b, expected %b",
                         checked, got.out_error, want.out_error));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_data;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  conversion_scoreboard sb = new();

  // alphabet the stimulus draws digits from, kept in step with the block
  logic [2*CFG_DATA_W-1:0] src_alpha = '0;
  int                      src_len   = 2;
  bit                      idle_on   = 1'b1;
  bit                      hold_armed = 1'b0;
  bit                      hold_done  = 1'b0;
  int                      items_sent = 0;
  int                      cycle_count = 0;

  radix_string_converter_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic in_item_t make_item(logic [CHAR_W-1:0] c, logic last);
    in_item_t it;
    it.in_char = c;
    it.in_last = last;
    return it;
  endfunction

  function automatic logic [2*CFG_DATA_W-1:0] pack_text(string text);
    logic [2*CFG_DATA_W-1:0] a;
    a = '0;
    for (int i = 0; i < text.len(); i++) a[8*i +: 8] = text[i];
    return a;
  endfunction

  // len distinct usable characters, random bytes above them
  function automatic logic [2*CFG_DATA_W-1:0] random_alphabet(int len);
    logic [2*CFG_DATA_W-1:0] a;
    logic [CHAR_W-1:0]       c;
    bit                      taken [256];
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      if (i < len) begin
        c = 8'($urandom_range(1, 255));
        while (taken[c] || c == CHAR_PLUS || c == CHAR_MINUS || conversion_scoreboard::blank(c))
          c = 8'($urandom_range(1, 255));
        taken[c] = 1'b1;
        a[8*i +: 8] = c;
      end else begin
        a[8*i +: 8] = 8'($urandom_range(0, 255));
      end
    end
    return a;
  endfunction

  function automatic void break_alphabet(input fault_t fault, inout int len,
                                         inout logic [2*CFG_DATA_W-1:0] a);
    int r;
    int i;
    int j;
    case (fault)
      FAULT_SHORT: len = $urandom_range(0, 1);
      FAULT_LONG:  len = $urandom_range(MAX_BASE + 1, 31);
      FAULT_BAD_CHAR: begin
        r = $urandom_range(0, 8);
        i = $urandom_range(0, len - 1);
        a[8*i +: 8] = (r == 0) ? CHAR_NUL : (r == 1) ? CHAR_PLUS : (r == 2) ? CHAR_MINUS :
                      (r == 3) ? CHAR_SPACE : CHAR_TAB + 8'(r - 4);
      end
      FAULT_REPEAT: begin
        i = $urandom_range(0, len - 2);
        j = $urandom_range(i + 1, len - 1);
        a[8*j +: 8] = a[8*i +: 8];
      end
      default: ;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_char(input in_item_t it);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while (idle_on && $urandom_range(99) < IDLE_PCT) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_char(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_char(make_item(text[i], i == text.len() - 1));
  endtask

  // mostly blanks, signs, digits and some trailing junk; noisy strings are random bytes
  task automatic send_number(input bit noisy);
    in_item_t s[$];
    int       lim;
    int       n;
    int       k;
    lim = (src_len > ALPHA_SIZE) ? ALPHA_SIZE : src_len;
    if (noisy) begin
      n = $urandom_range(1, 6);
      repeat (n) s.push_back(make_item(8'($urandom_range(0, 255)), 1'b0));
    end else begin
      n = $urandom_range(0, 2);
      repeat (n) begin
        k = $urandom_range(0, 5);
        s.push_back(make_item((k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k), 1'b0));
      end
      n = ($urandom_range(99) < 60) ? 0 : $urandom_range(1, 3);
      repeat (n) s.push_back(make_item($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS, 1'b0));
      // occasional long runs so the accumulator wraps
      n = ($urandom_range(99) < 8) ? $urandom_range(11, 40) : $urandom_range(0, 9);
      if (lim == 0) n = 0;
      repeat (n) s.push_back(make_item(src_alpha[8*$urandom_range(0, lim - 1) +: 8], 1'b0));
      if ($urandom_range(99) < 20) begin
        n = $urandom_range(1, 3);
        repeat (n) s.push_back(make_item(8'($urandom_range(0, 255)), 1'b0));
      end
    end
    if (s.size() == 0) s.push_back(make_item(8'($urandom_range(0, 255)), 1'b0));
    s[s.size() - 1].in_last = 1'b1;
    foreach (s[i]) send_char(s[i]);
  endtask

  // keeps cfg_write high across back to back writes
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(input int slen, input int tlen,
                           input logic [2*CFG_DATA_W-1:0] salpha,
                           input logic [2*CFG_DATA_W-1:0] talpha);
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    // upper bits of a length write are don't care
    write_reg(CFG_SOURCE_LENGTH, {junk[CFG_DATA_W-1:LEN_W], LEN_W'(slen)});
    write_reg(CFG_TARGET_LENGTH, {~junk[CFG_DATA_W-1:LEN_W], LEN_W'(tlen)});
    write_reg(CFG_SOURCE_DIGITS_LOW, salpha[CFG_DATA_W-1:0]);
    write_reg(CFG_SOURCE_DIGITS_HIGH, salpha[2*CFG_DATA_W-1:CFG_DATA_W]);
    write_reg(CFG_TARGET_DIGITS_LOW, talpha[CFG_DATA_W-1:0]);
    write_reg(CFG_TARGET_DIGITS_HIGH, talpha[2*CFG_DATA_W-1:CFG_DATA_W]);
    write_reg(CFG_UNMAPPED, junk);
    cfg_write <= 1'b0;
    src_alpha = salpha;
    src_len   = slen;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_chars.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // results are taken at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_char(out_data);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // output side: random stalls plus one long hold that backs the block up
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done && out_valid) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end
      out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin
    int                      phase_no;
    int                      budget;
    int                      slen;
    int                      tlen;
    fault_t                  fault;
    logic [2*CFG_DATA_W-1:0] salpha;
    logic [2*CFG_DATA_W-1:0] talpha;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset alphabets are all nul, so any string ends in an error item
    send_text("1");
    wait_drained();

    // hex in, binary out: widest output run
    configure(MAX_BASE, 2, pack_text("0123456789ABCDEF"), pack_text("01"));
    send_text("\t-+-1");
    send_text("-0");
    send_text("80000000");
    send_text("FFFFFFFFF");
    wait_drained();

    items_sent = 0;
    hold_armed = 1'b1;
    phase_no   = 0;
    while (items_sent < RANDOM_ITEMS) begin
      slen = $urandom_range(2, MAX_BASE);
      tlen = $urandom_range(2, MAX_BASE);
      if (phase_no == 0) begin
        slen = MAX_BASE;
        tlen = 2;
      end else if (phase_no == 1) begin
        slen = 2;
        tlen = MAX_BASE;
      end
      salpha = random_alphabet(slen);
      talpha = random_alphabet(tlen);
      // one phase for each way an alphabet can be rejected, then now and then at random
      if (phase_no >= 2 && phase_no <= 5)
        fault = fault_t'(phase_no - 1);
      else if ($urandom_range(99) < 15)
        fault = fault_t'($urandom_range(FAULT_SHORT, FAULT_REPEAT));
      else
        fault = FAULT_NONE;
      budget = 20;
      if (fault != FAULT_NONE) begin
        budget = 8;
        if ($urandom_range(1)) break_alphabet(fault, slen, salpha);
        else break_alphabet(fault, tlen, talpha);
      end
      configure(slen, tlen, salpha, talpha);
      // one phase runs with no gaps and no stalls at all
      idle_on = (phase_no != 7);
      budget += items_sent;
      while (items_sent < budget) send_number($urandom_range(99) < 12);
      wait_drained();
      phase_no++;
    end

    idle_on = 1'b1;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+src
src/rsc_pkg.sv
src/rsc_ram.sv
src/rsc_divider.sv
src/radix_string_converter_core.sv
sim/testbench.sv
